>>> hdl/tst_pkg.sv
// Package: function codes and constants for the timestamp trigger table.
`default_nettype none

package tst_pkg;

    typedef enum logic [1:0] {
        FUNC_ADVANCE = 2'd0,
        FUNC_ARM     = 2'd1,
        FUNC_DISABLE = 2'd2,
        FUNC_QUERY   = 2'd3
    } func_t;

    localparam int unsigned INDEX_W  = 5;
    localparam int unsigned AMOUNT_W = 16;
    localparam int unsigned STAMP_W  = 32;

    localparam logic [AMOUNT_W-1:0] NEVER_VAL      = 16'hFFFF;
    localparam logic [AMOUNT_W-1:0] SAT_VAL        = 16'h7FFE;
    localparam logic [STAMP_W-1:0]  DISABLED_STAMP = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

>>> hdl/timestamp_trigger_table.sv
// Top level: tick counter and trigger timestamp table with per-item query result.
// Pipeline: input register, then result register; an accepted input moves on to the
//   result register once the result slot is free or being emptied.
// Throughput: one item per cycle unless stalled; the op, table write and result all
//   settle in the single combinational pass between the input and result registers.
// Reset: tick clears to zero, every trigger reads as disabled (all ones), both
//   pipeline registers empty.
`default_nettype none

module timestamp_trigger_table
    import tst_pkg::*;
#(
    parameter int unsigned TRIGGERS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [1:0]          func,
    input  wire logic [INDEX_W-1:0]  trigger_index,
    input  wire logic [AMOUNT_W-1:0] amount,

    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [AMOUNT_W-1:0]      elapsed,
    output logic [AMOUNT_W-1:0]      elapsed_wrap,
    output logic                     fired_now,
    output logic                     is_after,
    output logic                     is_before,
    output logic                     is_exactly
);

    // Only indexes reachable through the 5-bit port get storage.
    localparam int unsigned MAX_REACH = 1 << INDEX_W;
    localparam int unsigned DEPTH     = (TRIGGERS < MAX_REACH) ? TRIGGERS : MAX_REACH;
    localparam int unsigned TAB_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic                s1_valid_reg;
    logic                s1_valid_next;
    func_t               s1_func_reg;
    logic [INDEX_W-1:0]  s1_index_reg;
    logic [AMOUNT_W-1:0] s1_amount_reg;

    // Result register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [AMOUNT_W-1:0] elapsed_reg;
    logic [AMOUNT_W-1:0] elapsed_wrap_reg;
    logic                fired_now_reg;
    logic                is_after_reg;
    logic                is_before_reg;
    logic                is_exactly_reg;

    // State
    logic [STAMP_W-1:0]  tick_reg;
    logic [STAMP_W-1:0]  tick_next;
    logic [STAMP_W-1:0]  stamp_reg [DEPTH];

    logic in_accept;
    logic s1_advance;

    // The item in the input register moves on whenever the result slot is free
    // or being emptied this cycle.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    assign s1_valid_next  = in_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_advance ? 1'b1 :
                            ((out_valid_reg && !out_stall) ? 1'b0 : out_valid_reg);

    // ---------------------------------------------------------------
    // Single pass: apply the op, then measure the addressed trigger
    // ---------------------------------------------------------------
    logic                in_range;
    logic [TAB_W-1:0]    tab_addr;
    logic [STAMP_W-1:0]  stamp_read;
    logic [STAMP_W-1:0]  stamp_arm;
    logic [STAMP_W-1:0]  stamp_post;
    logic [STAMP_W-1:0]  diff;
    logic                never;
    logic [AMOUNT_W-1:0] el;
    logic                wr_en;

    assign in_range = 32'(s1_index_reg) < TRIGGERS;
    assign tab_addr = TAB_W'(s1_index_reg);
    assign stamp_arm = tick_reg + STAMP_W'(s1_amount_reg);

    always_comb
    begin
        stamp_read = in_range ? stamp_reg[tab_addr] : DISABLED_STAMP;
        tick_next  = tick_reg;
        stamp_post = stamp_read;
        wr_en      = 1'b0;
        case (s1_func_reg)
            FUNC_ADVANCE:
            begin
                tick_next = tick_reg + 32'd1;
            end
            FUNC_ARM:
            begin
                if (in_range)
                begin
                    stamp_post = stamp_arm;
                    wr_en      = 1'b1;
                end
            end
            FUNC_DISABLE:
            begin
                if (in_range)
                begin
                    stamp_post = DISABLED_STAMP;
                    wr_en      = 1'b1;
                end
            end
            default:
            begin
                stamp_post = stamp_read;
            end
        endcase
    end

    assign diff  = tick_next - stamp_post;
    // A stamp of all ones is disabled; a stamp above the tick has not fired.
    assign never = (stamp_post == DISABLED_STAMP) || (tick_next < stamp_post);

    always_comb
    begin
        if (never)
            el = NEVER_VAL;
        else if (diff > STAMP_W'(SAT_VAL))
            el = SAT_VAL;
        else
            el = diff[AMOUNT_W-1:0];
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tick_reg      <= '0;
            for (int i = 0; i < int'(DEPTH); i++)
            begin
                stamp_reg[i] <= DISABLED_STAMP;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_advance)
            begin
                tick_reg <= tick_next;
                if (wr_en)
                begin
                    stamp_reg[tab_addr] <= stamp_post;
                end
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_func_reg   <= func_t'(func);
            s1_index_reg  <= trigger_index;
            s1_amount_reg <= amount;
        end
        if (s1_advance)
        begin
            elapsed_reg      <= el;
            elapsed_wrap_reg <= diff[AMOUNT_W-1:0];
            fired_now_reg    <= (stamp_post == tick_next);
            is_after_reg     <= (el != NEVER_VAL) && (el >= s1_amount_reg);
            is_before_reg    <= (el != NEVER_VAL) && (el < s1_amount_reg);
            is_exactly_reg   <= (el == s1_amount_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign elapsed      = elapsed_reg;
    assign elapsed_wrap = elapsed_wrap_reg;
    assign fired_now    = fired_now_reg;
    assign is_after     = is_after_reg;
    assign is_before    = is_before_reg;
    assign is_exactly   = is_exactly_reg;

endmodule

`default_nettype wire

>>> hdl/tst_checker.sv
// Checker: port-level assertions for the timestamp trigger table, bound to the top.
`default_nettype none

module tst_checker
    import tst_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire logic [AMOUNT_W-1:0] elapsed,
    input wire logic [AMOUNT_W-1:0] elapsed_wrap,
    input wire logic                fired_now,
    input wire logic                is_after,
    input wire logic                is_before
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its gap fields.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(elapsed) && $stable(elapsed_wrap))
        else $error("stalled result changed");

    // After and before never both hold.
    a_after_before: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_after && is_before))
        else $error("after and before both set");

    // A trigger that is disabled or pending is neither after nor before.
    a_never_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (elapsed == NEVER_VAL) |-> !is_after && !is_before)
        else $error("flags set on a trigger that has not fired");

    // Fired now on a live trigger means zero gap.
    a_elapsed_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fired_now && (elapsed != NEVER_VAL) |-> (elapsed == 16'd0)
            && (elapsed_wrap == 16'd0))
        else $error("fired now with nonzero gap");

endmodule

bind timestamp_trigger_table tst_checker u_tst_checker (.*);

`default_nettype wire
